>>> hw/rtl/fmv_pkg.sv
// fmv_pkg: shared types and constants of the feed message validator
`timescale 1ns / 1ps

package fmv_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int SYMBOL_CHARS  = 8;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int TBL_CW        = TBL_AW + 1;
  localparam int REF_W         = 64;

  // ascii codes used by the checks
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;

  typedef enum logic [2:0] {
    CMD_SYSTEM = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_EXEC   = 3'd2,
    CMD_CANCEL = 3'd3,
    CMD_DELETE = 3'd4
  } fmv_cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LENGTH = 3'd1,
    ST_TYPE   = 3'd2,
    ST_GAP    = 3'd3,
    ST_SYMBOL = 3'd4,
    ST_DUP    = 3'd5
  } fmv_status_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [7:0]       type_byte;
    logic [15:0]      seq_num;
    logic [63:0]      symbol_chars;
    logic [REF_W-1:0] order_reference;
  } fmv_in_t;

  typedef struct packed {
    fmv_status_t status;
    logic [31:0] gap_total;
    logic [31:0] invalid_total;
    logic [31:0] duplicate_total;
  } fmv_out_t;

  typedef struct packed {
    logic             start;
    logic [REF_W-1:0] refno;
  } fmv_probe_req_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic dup;
  } fmv_probe_stat_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_EVAL,
    T_PROBE,
    T_DONE
  } fmv_top_state_t;

  typedef enum logic [1:0] {
    P_CLEAR,
    P_IDLE,
    P_PROBE
  } fmv_probe_state_t;

endpackage

>>> hw/rtl/fmv_ram.sv
// fmv_ram: generic single write port ram with registered read
`timescale 1ns / 1ps

module fmv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fmv_probe.sv
// fmv_probe: order reference hash set with linear probing and clearing sweep
`timescale 1ns / 1ps

module fmv_probe
  import fmv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  fmv_probe_req_t  req,
  output fmv_probe_stat_t stat
);

  fmv_probe_state_t  state_r, state_nxt;
  logic [TBL_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [TBL_AW-1:0] slot_r, slot_nxt;
  logic [TBL_CW-1:0] cnt_r, cnt_nxt;
  logic [REF_W-1:0]  refno_r, refno_nxt;

  logic              we;
  logic [TBL_AW-1:0] waddr;
  logic [REF_W-1:0]  wdata;
  logic [TBL_AW-1:0] raddr;
  logic [REF_W-1:0]  rdata;

  fmv_ram #(
    .WIDTH(REF_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= P_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
    slot_r  <= slot_nxt;
    cnt_r   <= cnt_nxt;
    refno_r <= refno_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    refno_nxt    = refno_r;
    we           = 1'b0;
    waddr        = slot_r;
    wdata        = refno_r;
    raddr        = slot_r + TBL_AW'(1);
    stat         = '0;
    case (state_r)
      P_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = '0;
        clr_addr_nxt = clr_addr_r + TBL_AW'(1);
        if (clr_addr_r == '1) begin
          state_nxt = P_IDLE;
        end
      end
      P_IDLE: begin
        stat.ready = 1'b1;
        if (req.start) begin
          refno_nxt = req.refno;
          slot_nxt  = req.refno[TBL_AW-1:0];
          raddr     = req.refno[TBL_AW-1:0];
          cnt_nxt   = TBL_CW'(1);
          state_nxt = P_PROBE;
        end
      end
      P_PROBE: begin
        if (rdata == '0) begin
          // free slot: claim it
          we        = 1'b1;
          stat.done = 1'b1;
          state_nxt = P_IDLE;
        end else if (rdata == refno_r) begin
          stat.done = 1'b1;
          stat.dup  = 1'b1;
          state_nxt = P_IDLE;
        end else if (cnt_r == TBL_CW'(TABLE_ENTRIES)) begin
          // every slot visited, table full
          stat.done = 1'b1;
          stat.dup  = 1'b1;
          state_nxt = P_IDLE;
        end else begin
          slot_nxt = slot_r + TBL_AW'(1);
          cnt_nxt  = cnt_r + TBL_CW'(1);
        end
      end
      default: begin
        state_nxt = P_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/feed_message_validator.sv
// feed_message_validator: top level, message checks, counters and result register
`timescale 1ns / 1ps

// checks one decoded market-feed message per item and returns one result item
// with a status code and the gap, invalid and duplicate counters as they stand
// after that message. after reset the reference table is swept clear, one
// entry a cycle; no item is accepted during the sweep. an item is taken in
// and then evaluated. an add message that passes the type, tracking and
// symbol checks and carries a non-zero order reference also walks the
// hash table at one slot per cycle through the registered-read table ram,
// visiting at most all TABLE_ENTRIES slots when the table is full. one item
// is worked on at a time; a finished result waits in the output register
// while the next item is taken in.
module feed_message_validator
  import fmv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fmv_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output fmv_out_t out_item
);

  fmv_top_state_t state_r, state_nxt;
  fmv_in_t        item_r;
  fmv_status_t    status_r;

  // tracking state and wrapping counters
  logic        started_r, started_nxt;
  logic [15:0] last_r, last_nxt;
  logic [31:0] gap_r, gap_nxt;
  logic [31:0] inv_r, inv_nxt;
  logic [31:0] dup_r, dup_nxt;

  logic     out_valid_r, out_valid_nxt;
  fmv_out_t out_item_r;

  fmv_probe_req_t  preq;
  fmv_probe_stat_t pstat;

  logic        res_valid;
  fmv_status_t res_status;
  logic        load_out;
  logic        in_order;
  logic        sym_ok;

  // symbol passes if every byte is alphanumeric or space and one is not space;
  // trailing spaces are spaces, so trimming needs no search
  function automatic logic symbol_good(input logic [63:0] chars);
    logic       ok;
    logic       any;
    logic [7:0] c;
    ok  = 1'b1;
    any = 1'b0;
    for (int i = 0; i < SYMBOL_CHARS; i++) begin
      c = chars[63 - 8 * i -: 8];
      if (c != CH_SPACE) begin
        any = 1'b1;
        if (!((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
              (c >= 8'h61 && c <= 8'h7a))) begin
          ok = 1'b0;
        end
      end
    end
    return ok && any;
  endfunction

  fmv_probe u_probe (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (preq),
    .stat (pstat)
  );

  assign in_ready  = (state_r == T_IDLE) && pstat.ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // first number always in order; 65535 then 0 is in order
  assign in_order = !started_r || (item_r.seq_num == 16'(last_r + 16'd1));
  assign sym_ok   = symbol_good(item_r.symbol_chars);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      started_r   <= 1'b0;
      last_r      <= '0;
      gap_r       <= '0;
      inv_r       <= '0;
      dup_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      last_r      <= last_nxt;
      gap_r       <= gap_nxt;
      inv_r       <= inv_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    if (res_valid) begin
      status_r <= res_status;
    end
    if (load_out) begin
      out_item_r <= '{status:          res_status,
                      gap_total:       gap_nxt,
                      invalid_total:   inv_nxt,
                      duplicate_total: dup_nxt};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    last_nxt    = last_r;
    gap_nxt     = gap_r;
    inv_nxt     = inv_r;
    dup_nxt     = dup_r;
    preq        = '0;
    preq.refno  = item_r.order_reference;
    res_valid   = 1'b0;
    res_status  = ST_OK;
    load_out    = 1'b0;

    case (state_r)
      T_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = T_EVAL;
        end
      end
      T_EVAL: begin
        case (item_r.command)
          CMD_SYSTEM, CMD_EXEC, CMD_CANCEL, CMD_DELETE: begin
            started_nxt = 1'b1;
            last_nxt    = item_r.seq_num;
            res_valid   = 1'b1;
            if (!in_order) begin
              gap_nxt    = gap_r + 32'd1;
              res_status = ST_GAP;
            end
          end
          CMD_ADD: begin
            if (item_r.type_byte != CH_A) begin
              // other known types have the wrong length for an add
              res_valid = 1'b1;
              inv_nxt   = inv_r + 32'd1;
              if (item_r.type_byte == CH_S || item_r.type_byte == CH_E ||
                  item_r.type_byte == CH_C || item_r.type_byte == CH_D) begin
                res_status = ST_LENGTH;
              end else begin
                res_status = ST_TYPE;
              end
            end else begin
              started_nxt = 1'b1;
              last_nxt    = item_r.seq_num;
              if (!in_order) begin
                gap_nxt    = gap_r + 32'd1;
                res_valid  = 1'b1;
                res_status = ST_GAP;
              end else if (!sym_ok) begin
                inv_nxt    = inv_r + 32'd1;
                res_valid  = 1'b1;
                res_status = ST_SYMBOL;
              end else if (item_r.order_reference == '0) begin
                // reference zero is accepted and never stored
                res_valid  = 1'b1;
                res_status = ST_OK;
              end else begin
                preq.start = 1'b1;
                state_nxt  = T_PROBE;
              end
            end
          end
          default: begin
            // unknown command: no tracking state or counter moves
            res_valid  = 1'b1;
            res_status = ST_TYPE;
          end
        endcase
      end
      T_PROBE: begin
        if (pstat.done) begin
          res_valid = 1'b1;
          if (pstat.dup) begin
            dup_nxt    = dup_r + 32'd1;
            res_status = ST_DUP;
          end
        end
      end
      T_DONE: begin
        // result held until the output register frees up
        res_valid  = 1'b1;
        res_status = status_r;
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase

    if (res_valid) begin
      if (!out_valid_r || out_ready) begin
        load_out  = 1'b1;
        state_nxt = T_IDLE;
      end else begin
        state_nxt = T_DONE;
      end
    end
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

endmodule

>>> bench/tb_feed_message_validator.sv
// tb_feed_message_validator: self-checking testbench of the feed message validator
`timescale 1ns / 1ps

// drives decoded feed messages into the validator with bursty valid and a stalling
// receiver, predicts each result item from a model of the tracking check, the
// type and symbol checks and the linear-probing reference set, and compares every
// result item field by field in order
module tb_feed_message_validator;
  import fmv_pkg::*;

  // idle cycles (nothing accepted on either side) before the run is abandoned;
  // covers the clearing sweep after reset and long probe chains with margin
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_REPORTS    = 40;

  // characters for building symbols
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_Z       = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  fmv_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  fmv_out_t out_item;

  int          burst_left;
  int          verdicts_seen;
  int          idle_cycles;
  logic [63:0] ref_pool [$];

  // a symbol byte is good when it is a digit, a letter or a space
  function automatic bit sym_char_ok(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A && c <= CH_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c == CH_SPACE);
  endfunction

  // model of the validator: tracking, counters, reference set and the queue of
  // result items still to come
  class validator_model;
    bit          started;
    logic [15:0] last_tn;
    logic [31:0] gap_cnt;
    logic [31:0] invalid_cnt;
    logic [31:0] dup_cnt;
    logic [63:0] tbl [TABLE_ENTRIES];
    fmv_out_t    verdicts [$];
    int          errors;

    function new();
      started     = 1'b0;
      last_tn     = '0;
      gap_cnt     = '0;
      invalid_cnt = '0;
      dup_cnt     = '0;
      errors      = 0;
      foreach (tbl[i]) tbl[i] = '0;
    endfunction

    // first number is taken as is; afterwards anything but last+1 is a gap,
    // and the new number is adopted either way
    function bit advance_tracking(logic [15:0] tn);
      bit in_order;
      in_order = !started || (tn == 16'(last_tn + 16'd1));
      if (!in_order) gap_cnt++;
      started = 1'b1;
      last_tn = tn;
      return in_order;
    endfunction

    function void note_message(fmv_in_t m);
      fmv_out_t               r;
      logic [7:0]             ch [SYMBOL_CHARS];
      int                     len;
      bit                     sym_ok;
      bit                     settled;
      bit                     dup;
      logic [TBL_AW-1:0]      home;
      logic [TBL_AW-1:0]      slot;
      r = '0;
      r.status = ST_OK;
      case (m.command)
        CMD_SYSTEM, CMD_EXEC, CMD_CANCEL, CMD_DELETE: begin
          if (!advance_tracking(m.seq_num)) r.status = ST_GAP;
        end
        CMD_ADD: begin
          if (m.type_byte != CH_A) begin
            r.status = (m.type_byte inside {CH_S, CH_E, CH_C, CH_D}) ? ST_LENGTH : ST_TYPE;
            invalid_cnt++;
          end else if (!advance_tracking(m.seq_num)) begin
            r.status = ST_GAP;
          end else begin
            for (int i = 0; i < SYMBOL_CHARS; i++) ch[i] = m.symbol_chars[63 - 8*i -: 8];
            len = SYMBOL_CHARS;
            while (len > 0 && ch[len-1] == CH_SPACE) len--;
            sym_ok = (len > 0);
            for (int i = 0; i < len; i++) if (!sym_char_ok(ch[i])) sym_ok = 1'b0;
            if (!sym_ok) begin
              invalid_cnt++;
              r.status = ST_SYMBOL;
            end else if (m.order_reference != '0) begin
              home    = m.order_reference[TBL_AW-1:0];
              settled = 1'b0;
              dup     = 1'b0;
              for (int k = 0; k < TABLE_ENTRIES && !settled; k++) begin
                slot = home + TBL_AW'(k);
                if (tbl[slot] == '0) begin
                  tbl[slot] = m.order_reference;
                  settled   = 1'b1;
                end else if (tbl[slot] == m.order_reference) begin
                  settled = 1'b1;
                  dup     = 1'b1;
                end
              end
              if (!settled || dup) begin
                dup_cnt++;
                r.status = ST_DUP;
              end
            end
          end
        end
        default: r.status = ST_TYPE;
      endcase
      r.gap_total       = gap_cnt;
      r.invalid_total   = invalid_cnt;
      r.duplicate_total = dup_cnt;
      verdicts.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_verdict(fmv_out_t got);
      fmv_out_t want;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got status %0d",
                   $time, got.status);
        return;
      end
      want = verdicts.pop_front();
      if (got.status !== want.status) report("status", 32'(want.status), 32'(got.status));
      if (got.gap_total !== want.gap_total)
        report("gap_total", want.gap_total, got.gap_total);
      if (got.invalid_total !== want.invalid_total)
        report("invalid_total", want.invalid_total, got.invalid_total);
      if (got.duplicate_total !== want.duplicate_total)
        report("duplicate_total", want.duplicate_total, got.duplicate_total);
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  validator_model vm;

  feed_message_validator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // message builders
  // ---------------------------------------------------------------------------

  function automatic fmv_in_t msg(logic [2:0] cmd, logic [7:0] tb, logic [15:0] tn,
                                  logic [63:0] sym, logic [63:0] refno);
    fmv_in_t m;
    m.command         = cmd;
    m.type_byte       = tb;
    m.seq_num         = tn;
    m.symbol_chars    = sym;
    m.order_reference = refno;
    return m;
  endfunction

  // the tracking number that keeps the sequence in order
  function automatic logic [15:0] next_tracking();
    if (!vm.started) return 16'($urandom);
    return 16'(vm.last_tn + 16'd1);
  endfunction

  // 1 to 8 good characters, last one non-blank, padded with trailing spaces
  function automatic logic [63:0] good_symbol();
    int          len;
    int          r;
    logic [7:0]  c;
    logic [63:0] s;
    len = $urandom_range(1, SYMBOL_CHARS);
    s   = {SYMBOL_CHARS{CH_SPACE}};
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 69);
      if (r < 10) c = CH_ZERO + 8'(r);
      else if (r < 36) c = CH_A + 8'(r - 10);
      else if (r < 62) c = CH_LOWER_A + 8'(r - 36);
      else c = CH_SPACE;
      if (i == len - 1 && c == CH_SPACE) c = CH_A;
      s[63 - 8*i -: 8] = c;
    end
    return s;
  endfunction

  // either all blanks or a good symbol with one illegal byte planted in it
  function automatic logic [63:0] bad_symbol();
    logic [63:0] s;
    logic [7:0]  c;
    int          pos;
    if ($urandom_range(0, 9) == 0) return {SYMBOL_CHARS{CH_SPACE}};
    s = good_symbol();
    c = 8'($urandom);
    while (sym_char_ok(c)) c = 8'($urandom);
    pos = $urandom_range(0, SYMBOL_CHARS - 1);
    s[63 - 8*pos -: 8] = c;
    return s;
  endfunction

  // reuse of stored references, zero, clustered homes and fresh values
  function automatic logic [63:0] pick_reference();
    int          r;
    logic [63:0] refno;
    r = $urandom_range(0, 99);
    if (r < 25 && ref_pool.size() > 0) return ref_pool[$urandom_range(0, ref_pool.size() - 1)];
    if (r < 35) return '0;
    refno = {$urandom, $urandom};
    // a handful of home slots so that probe chains grow long
    if (r < 55) refno[TBL_AW-1:0] = TBL_AW'($urandom_range(0, 31));
    if (r >= 55 && r < 58) refno = '1;
    return refno;
  endfunction

  function automatic fmv_in_t well_formed_add(logic [63:0] refno);
    if (refno != '0) ref_pool.push_back(refno);
    return msg(CMD_ADD, CH_A, next_tracking(), good_symbol(), refno);
  endfunction

  function automatic fmv_in_t random_message();
    fmv_in_t m;
    int      r;
    m.command         = 3'($urandom_range(0, 7));
    m.type_byte       = 8'($urandom);
    m.seq_num         = 16'($urandom);
    m.symbol_chars    = {$urandom, $urandom};
    m.order_reference = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 55) begin
      m = well_formed_add(pick_reference());
    end else if (r < 73) begin
      // in-order message of one of the other kinds
      case ($urandom_range(0, 3))
        0: m.command = CMD_SYSTEM;
        1: m.command = CMD_EXEC;
        2: m.command = CMD_CANCEL;
        default: m.command = CMD_DELETE;
      endcase
      m.seq_num = next_tracking();
    end else if (r < 80) begin
      // add with a wrong type byte, often one of the other known kinds
      m.command = CMD_ADD;
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: m.type_byte = CH_S;
          1: m.type_byte = CH_E;
          2: m.type_byte = CH_C;
          default: m.type_byte = CH_D;
        endcase
      end
    end else if (r < 88) begin
      m = well_formed_add(pick_reference());
      m.symbol_chars = bad_symbol();
    end else if (r < 93) begin
      // known kind with a tracking number that is most likely out of order
      m.command = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 0) m.type_byte = CH_A;
    end else if (r < 97) begin
      m.command = 3'(CMD_DELETE) + 3'($urandom_range(1, 3));
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of items with random gaps, valid held until accepted
  // ---------------------------------------------------------------------------

  // entered and left at a falling edge
  task automatic send_msg(input fmv_in_t m);
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) < 7) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_item  <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    vm.note_message(m);
    burst_left--;
    @(negedge clk);
  endtask

  initial begin : stimulus
    vm         = new();
    burst_left = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: first number, every kind, duplicates, reference zero
    send_msg(msg(CMD_SYSTEM, 8'h00, 16'd100, '0, '0));
    send_msg(msg(CMD_EXEC,   8'hFF, 16'd101, '1, '1));
    send_msg(msg(CMD_CANCEL, 8'h00, 16'd102, '0, '0));
    send_msg(msg(CMD_DELETE, 8'h00, 16'd103, '0, '0));
    send_msg(msg(CMD_ADD, CH_A, 16'd104, "AAPL    ", 64'd1));
    send_msg(msg(CMD_ADD, CH_A, 16'd105, "AAPL    ", 64'd1));
    send_msg(msg(CMD_ADD, CH_A, 16'd106, "MSFT    ", '0));
    send_msg(msg(CMD_ADD, CH_A, 16'd107, "MSFT    ", '0));
    // type byte failures leave tracking alone
    send_msg(msg(CMD_ADD, CH_S, 16'd0,     "IBM     ", 64'd5));
    send_msg(msg(CMD_ADD, CH_E, 16'd65535, "IBM     ", 64'd5));
    send_msg(msg(CMD_ADD, CH_C, 16'd9,     "IBM     ", 64'd5));
    send_msg(msg(CMD_ADD, CH_D, 16'd9,     "IBM     ", 64'd5));
    send_msg(msg(CMD_ADD, 8'h00, 16'd9,    "IBM     ", 64'd5));
    send_msg(msg(CMD_ADD, 8'hFF, 16'd9,    "IBM     ", 64'd5));
    // unused command codes
    send_msg(msg(3'(CMD_DELETE) + 3'd1, CH_A, 16'd108, "IBM     ", 64'd6));
    send_msg(msg(3'(CMD_DELETE) + 3'd3, CH_A, 16'd108, "IBM     ", 64'd6));
    // symbol checks: blank, bad byte, leading blanks, full width, all ones
    send_msg(msg(CMD_ADD, CH_A, 16'd108, "        ", 64'd7));
    send_msg(msg(CMD_ADD, CH_A, 16'd109, "A.B     ", 64'd7));
    send_msg(msg(CMD_ADD, CH_A, 16'd110, "  ZZzz9 ", '1));
    send_msg(msg(CMD_ADD, CH_A, 16'd111, "Zz09azAZ", 64'h1001));
    send_msg(msg(CMD_ADD, CH_A, 16'd112, '1, 64'd8));
    // gap on a plain message, then on an add
    send_msg(msg(CMD_SYSTEM, 8'h00, 16'd200, '0, '0));
    send_msg(msg(CMD_ADD, CH_A, 16'd300, '1, 64'd9));
    // tracking wrap, then a symbol of zero bytes
    send_msg(msg(CMD_SYSTEM, 8'h00, 16'd65535, '0, '0));
    send_msg(msg(CMD_ADD, CH_A, 16'd0, "X       ", {$urandom, $urandom}));
    send_msg(msg(CMD_ADD, CH_A, 16'd1, '0, 64'd10));

    repeat (RANDOM_ITEMS) send_msg(random_message());

    // tail: fresh references, stored ones found again, reference zero
    repeat (3) send_msg(well_formed_add({$urandom, $urandom}));
    repeat (2) send_msg(well_formed_add(ref_pool[$urandom_range(0, ref_pool.size() - 1)]));
    send_msg(well_formed_add('0));
    send_msg(random_message());

    in_valid <= 1'b0;
    while (vm.pending() != 0) @(posedge clk);
    // room for any stray result item
    repeat (100) @(posedge clk);
    if (vm.errors == 0 && vm.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: ready steps through a random 16-bit pattern, one bit at a time, with
  // one long hold-off while the sender keeps offering, so the block backs up
  // ---------------------------------------------------------------------------
  initial begin : receiver
    logic [15:0] pattern;
    int          phase;
    bit          held;
    out_ready = 1'b0;
    pattern   = '1;
    phase     = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && verdicts_seen >= 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (phase % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: pattern = '1;
          1: pattern = 16'($urandom) | 16'h1;
          2: pattern = 16'($urandom | $urandom);
          default: pattern = 16'($urandom & $urandom) | 16'h1;
        endcase
      end
      out_ready <= pattern[phase % 16];
      phase++;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and watchdog, both on the rising edge
  // ---------------------------------------------------------------------------
  initial begin
    verdicts_seen = 0;
    idle_cycles   = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        vm.check_verdict(out_item);
        verdicts_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

endmodule

>>> sim.f
hw/rtl/fmv_pkg.sv
hw/rtl/fmv_ram.sv
hw/rtl/fmv_probe.sv
hw/rtl/feed_message_validator.sv
bench/tb_feed_message_validator.sv
